// ----- design/tns_synthesis_fir_defines.svh -----
// Assertion macros shared by the checker of the TNS synthesis filter.
// Needs a clk_i and an active-low rst_ni in the scope that uses them.
`ifndef TNS_SYNTHESIS_FIR_DEFINES_SVH
`define TNS_SYNTHESIS_FIR_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define TSF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property on every rising clock edge, reset included
`define TSF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ----- design/tsf_pkg.sv -----
// Shared types and constants of the TNS synthesis filter.
// Used by the controller, the datapath and the top level; no dependencies.
package tsf_pkg;

  // Field widths fixed by the item format
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 4;
  localparam int CODE_W = 16;

  // Command codes carried in the input tuser
  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

  // Dequantizer: |q|/(4.5+|q|) rounded is (4a*2^F + 2a + 9) / (4a + 18)
  localparam int DQ_NUM_BIAS = 9;
  localparam int DQ_DEN_BIAS = 18;
  // Divisor 4a + 18 stays below 2^18 for a 16-bit code
  localparam int DEN_W       = CODE_W + 2;
  // Dividend width is WEIGHT_FRAC_BITS plus this
  localparam int NUM_EXT     = CODE_W + 2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic clear_frame;
    logic div_step;
    logic wgt_write;
    logic mac_step;
    logic commit;
  } tsf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_last;
    logic mac_last;
    logic out_free;
  } tsf_stat_t;

endpackage

// ----- design/tns_synthesis_fir.sv -----
// Sample item: one shared multiply per tap, a flush state to drain the product register,
// then rounding into the output register, which waits while a previous result is stalled.
// A new item is taken only once the previous one is finished and the sequencer is idle.
// Coefficient load: run by the bit-serial divider, then the tap weight is written.
// Frame start and unused commands complete on acceptance, in the idle state.
// Reset (rst_ni low, asynchronous) zeroes all weights and history, empties the output.
module tns_synthesis_fir #(
  parameter int MAX_ORDER        = 12,
  parameter int SAMPLE_BITS      = 32,
  parameter int WEIGHT_FRAC_BITS = 22,
  localparam int IN_DATA_W  =
    ((tsf_pkg::IDX_W + tsf_pkg::CODE_W + SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // coef_index, coef_code, sample_in, zero padding (lowest bit up)
  input  logic [IN_DATA_W-1:0]          s_axis_tdata_i,
  // command
  input  logic [tsf_pkg::CMD_W-1:0]     s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // sample_out, zero padding (lowest bit up)
  output logic [OUT_DATA_W-1:0]         m_axis_tdata_o,
  // saturated
  output logic [0:0]                    m_axis_tuser_o
);

  localparam int IDX_W  = tsf_pkg::IDX_W;
  localparam int CODE_W = tsf_pkg::CODE_W;

  tsf_pkg::tsf_cmd_t  ctrl;
  tsf_pkg::tsf_stat_t stat;

  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          saturated;

  tsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_cmd_i   (s_axis_tuser_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  tsf_datapath #(
    .MAX_ORDER        (MAX_ORDER),
    .SAMPLE_BITS      (SAMPLE_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .coef_index_i (s_axis_tdata_i[IDX_W-1:0]),
    .coef_code_i  (s_axis_tdata_i[IDX_W+CODE_W-1:IDX_W]),
    .sample_in_i  (s_axis_tdata_i[IDX_W+CODE_W+SAMPLE_BITS-1:IDX_W+CODE_W]),
    .sample_out_o (sample_out),
    .saturated_o  (saturated),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i)
  );

  // Pack the result, zero fill up to whole bytes
  assign m_axis_tdata_o = OUT_DATA_W'(unsigned'(sample_out));
  assign m_axis_tuser_o = saturated;

endmodule

// ----- design/tsf_ctrl.sv -----
// Sequencer of the TNS synthesis filter: takes items and steps the datapath.
// Depends on tsf_pkg for the command codes and the command/status structs.
module tsf_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tsf_pkg::CMD_W-1:0]     in_cmd_i,
  input  tsf_pkg::tsf_stat_t            stat_i,
  output tsf_pkg::tsf_cmd_t             ctrl_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_MAC   = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state_q, state_d;

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ctrl_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          unique case (in_cmd_i)
            tsf_pkg::CMD_START:  ctrl_o.clear_frame = 1'b1;
            tsf_pkg::CMD_LOAD:   state_d = ST_DIV;
            tsf_pkg::CMD_SAMPLE: state_d = ST_MAC;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        ctrl_o.wgt_write = 1'b1;
        state_d = ST_IDLE;
      end
      ST_MAC: begin
        ctrl_o.mac_step = 1'b1;
        if (stat_i.mac_last) state_d = ST_FLUSH;
      end
      // let the last product reach the accumulator
      ST_FLUSH: state_d = ST_EMIT;
      ST_EMIT: begin
        if (stat_i.out_free) begin
          ctrl_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/tsf_datapath.sv -----
// Datapath of the TNS synthesis filter: dequantizing divider, tap store,
// sample history, shared multiply-accumulate and the output register.
// Depends on tsf_pkg; driven by tsf_ctrl through tsf_cmd_t.
module tsf_datapath #(
  parameter int MAX_ORDER        = 12,
  parameter int SAMPLE_BITS      = 32,
  parameter int WEIGHT_FRAC_BITS = 22
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tsf_pkg::tsf_cmd_t                     ctrl_i,
  output tsf_pkg::tsf_stat_t                    stat_o,
  input  logic [tsf_pkg::IDX_W-1:0]             coef_index_i,
  input  logic signed [tsf_pkg::CODE_W-1:0]     coef_code_i,
  input  logic signed [SAMPLE_BITS-1:0]         sample_in_i,
  output logic signed [SAMPLE_BITS-1:0]         sample_out_o,
  output logic                                  saturated_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i
);

  localparam int F       = WEIGHT_FRAC_BITS;
  localparam int WGT_W   = F + 2;
  localparam int PROD_W  = SAMPLE_BITS + WGT_W;
  localparam int ACC_W   = PROD_W + $clog2(MAX_ORDER + 1);
  localparam int Y_W     = ACC_W - F;
  localparam int QUO_W   = F + 1;
  localparam int NUM_W   = F + tsf_pkg::NUM_EXT;
  localparam int DEN_W   = tsf_pkg::DEN_W;
  localparam int DCNT_W  = $clog2(QUO_W);
  localparam int TAP_W   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CODE_W  = tsf_pkg::CODE_W;

  // Captured item fields
  logic [tsf_pkg::IDX_W-1:0]     idx_q;
  logic                          neg_q;
  logic signed [SAMPLE_BITS-1:0] x_q;

  // Divider registers
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q;
  logic [QUO_W-1:0]  num_lo_q;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [DCNT_W-1:0] dcnt_q;

  // Filter state and accumulator
  logic signed [WGT_W-1:0]       wgt_q  [MAX_ORDER];
  logic signed [SAMPLE_BITS-1:0] hist_q [MAX_ORDER];
  logic [TAP_W-1:0]              tap_q;
  logic signed [PROD_W-1:0]      prod_q, prod_d;
  logic                          prod_vld_q;
  logic signed [ACC_W-1:0]       acc_q, acc_init, rnd;

  // Output register
  logic signed [SAMPLE_BITS-1:0] out_data_q, y_sat;
  logic                          out_sat_q, y_clip, out_vld_q;

  logic [CODE_W-1:0]       mag_in;
  logic [NUM_W-1:0]        num_in;
  logic [DEN_W-1:0]        den_in;
  logic [DEN_W:0]          rem_sh;
  logic                    fits;
  logic [WGT_W-1:0]        wmag;
  logic signed [WGT_W-1:0] wval;
  logic [Y_W-1:0]          y_full;
  logic [Y_W-SAMPLE_BITS:0] y_top;

  // Set up the division for the incoming code
  always_comb begin
    mag_in = coef_code_i[CODE_W-1] ? CODE_W'(-coef_code_i) : CODE_W'(coef_code_i);
    num_in = (NUM_W'(mag_in) << (F + 2)) + NUM_W'({mag_in, 1'b0})
           + NUM_W'(tsf_pkg::DQ_NUM_BIAS);
    den_in = DEN_W'({mag_in, 2'b00}) + DEN_W'(tsf_pkg::DQ_DEN_BIAS);
  end

  // One restoring division step: one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, num_lo_q[QUO_W-1]};
    fits   = (rem_sh >= {1'b0, den_q});
    rem_d  = fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
    quo_d  = {quo_q[QUO_W-2:0], fits};
    wmag   = {1'b0, quo_q};
    wval   = neg_q ? -wmag : wmag;
  end

  // Shared multiplier on the selected tap
  always_comb begin
    prod_d   = PROD_W'(wgt_q[tap_q]) * PROD_W'(hist_q[tap_q]);
    acc_init = ACC_W'(sample_in_i) <<< F;
  end

  // Round to nearest, ties up, then clip to the sample range
  always_comb begin
    rnd    = acc_q + (ACC_W'(1) << (F - 1));
    y_full = rnd[ACC_W-1:F];
    y_top  = y_full[Y_W-1:SAMPLE_BITS-1];
    y_clip = !((&y_top) || !(|y_top));
    y_sat  = y_clip ? {y_full[Y_W-1], {(SAMPLE_BITS-1){~y_full[Y_W-1]}}}
                    : y_full[SAMPLE_BITS-1:0];
  end

  // Capture the item and run the divider
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      idx_q    <= coef_index_i;
      neg_q    <= coef_code_i[CODE_W-1];
      x_q      <= sample_in_i;
      rem_q    <= DEN_W'(num_in[NUM_W-1:QUO_W]);
      num_lo_q <= num_in[QUO_W-1:0];
      den_q    <= den_in;
      quo_q    <= '0;
      dcnt_q   <= '0;
    end else if (ctrl_i.div_step) begin
      rem_q    <= rem_d;
      num_lo_q <= num_lo_q << 1;
      quo_q    <= quo_d;
      dcnt_q   <= dcnt_q + DCNT_W'(1);
    end
  end

  // Step the taps and subtract the products from the accumulator
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctrl_i.capture) begin
      tap_q <= '0;
      acc_q <= acc_init;
    end else begin
      if (ctrl_i.mac_step) tap_q <= tap_q + TAP_W'(1);
      if (prod_vld_q) acc_q <= acc_q - ACC_W'(prod_q);
    end
  end

  // Tap weights and sample history; frame start clears both
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < MAX_ORDER; t++) begin
        wgt_q[t]  <= '0;
        hist_q[t] <= '0;
      end
    end else if (ctrl_i.clear_frame) begin
      for (int t = 0; t < MAX_ORDER; t++) begin
        wgt_q[t]  <= '0;
        hist_q[t] <= '0;
      end
    end else begin
      for (int t = 0; t < MAX_ORDER; t++) begin
        if (ctrl_i.wgt_write && (int'(idx_q) == t)) wgt_q[t] <= wval;
      end
      if (ctrl_i.commit) begin
        hist_q[0] <= x_q;
        for (int t = 1; t < MAX_ORDER; t++) hist_q[t] <= hist_q[t-1];
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      out_data_q <= y_sat;
      out_sat_q  <= y_clip;
    end
  end

  // Control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.mac_step;
      if (ctrl_i.commit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign stat_o.div_last = (dcnt_q == DCNT_W'(QUO_W - 1));
  assign stat_o.mac_last = (tap_q == TAP_W'(MAX_ORDER - 1));
  assign stat_o.out_free = !out_vld_q || out_ready_i;

  assign sample_out_o = out_data_q;
  assign saturated_o  = out_sat_q;
  assign out_valid_o  = out_vld_q;

endmodule

// ----- design/tsf_checker.sv -----
// Port-level checks of the TNS synthesis filter, bound to the top level.
// Depends on tsf_pkg and the macros in tns_synthesis_fir_defines.svh.
`include "tns_synthesis_fir_defines.svh"

module tsf_checker #(
  parameter int SAMPLE_BITS = 32,
  localparam int OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic [tsf_pkg::CMD_W-1:0] s_axis_tuser_i,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [OUT_DATA_W-1:0]     m_axis_tdata_o,
  input logic [0:0]                m_axis_tuser_o
);

  logic in_busy_item;
  logic sat_sign;

  assign in_busy_item = s_axis_tvalid_i && s_axis_tready_o &&
                        (s_axis_tuser_i == tsf_pkg::CMD_LOAD ||
                         s_axis_tuser_i == tsf_pkg::CMD_SAMPLE);
  assign sat_sign = m_axis_tdata_o[SAMPLE_BITS-1];

  // A stalled result holds its payload
  `TSF_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

  // A clipped result sits at one end of the sample range
  `TSF_ASSERT(a_sat_value, m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o[SAMPLE_BITS-2:0] == {(SAMPLE_BITS-1){~sat_sign}}, "saturated result not at range limit")

  // Loads and samples keep the input side busy for the next cycle
  `TSF_ASSERT(a_busy_after_item, in_busy_item |=> !s_axis_tready_o, "input ready right after a multi-cycle item")

  // No result is offered during reset
  `TSF_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !m_axis_tvalid_o, "result valid during reset")

endmodule

bind tns_synthesis_fir tsf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_tsf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ----- tb/tb_tns_synthesis_fir.sv -----
// Self-checking testbench of the TNS synthesis filter tns_synthesis_fir.
// Predicts each filtered sample from its own tap and history copy; needs tsf_pkg.
module tb_tns_synthesis_fir;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W     = tsf_pkg::IDX_W;
  localparam int CODE_W    = tsf_pkg::CODE_W;
  localparam int CMD_W     = tsf_pkg::CMD_W;
  localparam logic [CMD_W-1:0] CMD_START  = tsf_pkg::CMD_START;
  localparam logic [CMD_W-1:0] CMD_LOAD   = tsf_pkg::CMD_LOAD;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = tsf_pkg::CMD_SAMPLE;

  localparam int ORDER     = 12;
  localparam int SMP_W     = 32;
  localparam int FRAC      = 22;
  localparam int WGT_W     = 24;
  localparam int IN_W      = ((IDX_W + CODE_W + SMP_W + 7) / 8) * 8;
  localparam int OUT_W     = ((SMP_W + 7) / 8) * 8;
  localparam int LIMIT     = 400000;
  localparam int TAIL      = 40;
  localparam int HOLD_LEN  = 300;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic signed [SMP_W-1:0] value;
    logic                    clipped;
  } filt_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  // coef_index, coef_code, sample_in, zero padding (lowest bit up)
  logic [IN_W-1:0]      s_axis_tdata_i;
  // command
  logic [CMD_W-1:0]     s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  // sample_out, zero padding (lowest bit up)
  logic [OUT_W-1:0]     m_axis_tdata_o;
  // saturated
  logic [0:0]           m_axis_tuser_o;

  // Predictor state: dequantized taps and past inputs, entry 0 is x[n-1]
  logic signed [WGT_W-1:0] tap_wgt [ORDER];
  logic signed [SMP_W-1:0] past_x  [ORDER];
  filt_result_t            filtered_q [$];

  int  error_count;
  int  cycle_count;
  bit  gaps_on;
  bit  stalls_on;
  bit  hold_req;

  tns_synthesis_fir u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run if the traffic never drains
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tns_synthesis_fir test failed");
    $finish;
  end

  // |q|/(4.5+|q|) in Q1.22, rounded to nearest, sign of q
  function automatic logic signed [WGT_W-1:0] dequant(logic signed [CODE_W-1:0] code);
    longint unsigned mag_q;
    longint unsigned num;
    longint unsigned den;
    longint          mag;
    mag_q = (code < 0) ? longint'(-longint'(code)) : longint'(code);
    num   = (2 * mag_q) << FRAC;
    den   = 2 * mag_q + 9;
    mag   = longint'((2 * num + den) / (2 * den));
    return (code < 0) ? WGT_W'(-mag) : WGT_W'(mag);
  endfunction

  // Update the predictor with one accepted item, queue the filtered sample
  task automatic filter_predict(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                logic signed [CODE_W-1:0] code,
                                logic signed [SMP_W-1:0] x);
    longint       acc;
    longint       y;
    filt_result_t res;
    case (cmd)
      CMD_START: begin
        for (int i = 0; i < ORDER; i++) begin
          tap_wgt[i] = '0;
          past_x[i]  = '0;
        end
      end
      CMD_LOAD: begin
        if (idx < ORDER) tap_wgt[idx] = dequant(code);
      end
      CMD_SAMPLE: begin
        acc = longint'(x) <<< FRAC;
        for (int i = 0; i < ORDER; i++)
          acc -= longint'(tap_wgt[i]) * longint'(past_x[i]);
        acc += longint'(1) <<< (FRAC - 1);
        y = acc >>> FRAC;
        res.clipped = 1'b0;
        if (y > longint'(32'sh7fffffff)) begin
          y = longint'(32'sh7fffffff);
          res.clipped = 1'b1;
        end
        if (y < -longint'(64'sh80000000)) begin
          y = -longint'(64'sh80000000);
          res.clipped = 1'b1;
        end
        res.value = SMP_W'(y);
        for (int i = ORDER - 1; i > 0; i--) past_x[i] = past_x[i-1];
        past_x[0] = x;
        filtered_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Offer one item, hold it until accepted, then maybe idle for a burst
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                           logic [CODE_W-1:0] code, logic [SMP_W-1:0] x);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {{(IN_W - IDX_W - CODE_W - SMP_W){1'b0}}, x, code, idx};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    filter_predict(cmd, idx, code, x);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Mix of full-range, small and extreme sample values
  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return 32'h7fffffff - $urandom_range(0, 3);
      1:       return 32'h80000000 + $urandom_range(0, 3);
      2, 3:    return SMP_W'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  // Mix of full-range, small and extreme coefficient codes
  function automatic logic [CODE_W-1:0] pick_code();
    case ($urandom_range(0, 4))
      0:       return ($urandom_range(0, 1) == 1) ? 16'h7fff : 16'h8000;
      1, 2:    return CODE_W'($signed($urandom_range(0, 40)) - 20);
      default: return CODE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Result checker: compare each item with the oldest prediction
  always @(posedge clk_i) begin
    filt_result_t exp_res;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected result item sample_out %0d saturated %0b",
                 $time, $signed(m_axis_tdata_o[SMP_W-1:0]), m_axis_tuser_o[0]);
        error_count++;
      end else begin
        exp_res = filtered_q.pop_front();
        if (m_axis_tdata_o[SMP_W-1:0] !== exp_res.value) begin
          $display("%0t: sample_out expected %0d actual %0d", $time,
                   exp_res.value, $signed(m_axis_tdata_o[SMP_W-1:0]));
          error_count++;
        end
        if (m_axis_tuser_o[0] !== exp_res.clipped) begin
          $display("%0t: saturated expected %0b actual %0b", $time,
                   exp_res.clipped, m_axis_tuser_o[0]);
          error_count++;
        end
      end
    end
  end

  // Receiver: random stall bursts, or one long hold-off on request
  initial begin
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  // Extremes, every command, ignored loads, saturation and frame clearing
  task automatic test_directed();
    send_item(CMD_START, 4'd0, 16'h0000, 32'h0);
    send_item(CMD_SAMPLE, 4'd0, 16'h0000, 32'h7fffffff);
    send_item(CMD_SAMPLE, 4'd0, 16'h0000, 32'h80000000);
    send_item(CMD_LOAD, 4'd0, 16'h7fff, 32'h0);
    send_item(CMD_LOAD, 4'd1, 16'h8000, 32'hffffffff);
    send_item(CMD_LOAD, 4'd11, 16'hffff, 32'h0);
    send_item(CMD_LOAD, 4'd2, 16'h0001, 32'h0);
    send_item(CMD_LOAD, 4'd5, 16'h0000, 32'h0);
    // Out-of-range taps are dropped
    send_item(CMD_LOAD, 4'd12, 16'h0005, 32'h0);
    send_item(CMD_LOAD, 4'd15, 16'hfff9, 32'h0);
    send_item(CMD_UNUSED, 4'hf, 16'hffff, 32'hffffffff);
    send_item(CMD_SAMPLE, 4'hf, 16'hffff, 32'h7fffffff);
    send_item(CMD_SAMPLE, 4'h0, 16'h0000, 32'h80000000);
    send_item(CMD_SAMPLE, 4'h0, 16'h0000, 32'h7fffffff);
    send_item(CMD_SAMPLE, 4'h0, 16'h0000, 32'h0);
    send_item(CMD_SAMPLE, 4'h0, 16'h0000, 32'hffffffff);
    // Frame start clears taps and history: pass-through again
    send_item(CMD_START, 4'hf, 16'hffff, 32'hffffffff);
    send_item(CMD_SAMPLE, 4'h0, 16'h0000, 32'd123);
    send_item(CMD_SAMPLE, 4'h0, 16'h0000, 32'hffff_fc00);
  endtask

  // Well-formed frames with random content, plus noise items
  task automatic run_frames(int n_items);
    int sent;
    int n_load;
    int n_samp;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        send_item(CMD_START, IDX_W'($urandom_range(0, 15)), CODE_W'($urandom_range(0, 65535)),
                  $urandom);
        n_load = $urandom_range(0, ORDER);
        n_samp = $urandom_range(1, 24);
        for (int i = 0; i < n_load; i++)
          send_item(CMD_LOAD, IDX_W'($urandom_range(0, ORDER - 1)), pick_code(), $urandom);
        for (int i = 0; i < n_samp; i++) begin
          // Reload a tap mid-frame now and then; history stays
          if ($urandom_range(0, 15) == 0)
            send_item(CMD_LOAD, IDX_W'($urandom_range(0, ORDER - 1)), pick_code(), $urandom);
          send_item(CMD_SAMPLE, IDX_W'($urandom_range(0, 15)), CODE_W'($urandom_range(0, 65535)),
                    pick_sample());
        end
        sent += 1 + n_load + n_samp;
      end else begin
        send_item(CMD_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 15)), pick_code(),
                  pick_sample());
        sent++;
      end
    end
  endtask

  task automatic test_random();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    run_frames(1300);
  endtask

  // Long receiver hold-off while samples keep coming: input must back up
  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    send_item(CMD_START, 4'd0, 16'h0000, 32'h0);
    for (int i = 0; i < ORDER; i++)
      send_item(CMD_LOAD, IDX_W'(i), pick_code(), 32'h0);
    for (int i = 0; i < 40; i++)
      send_item(CMD_SAMPLE, 4'd0, 16'h0000, pick_sample());
    gaps_on = 1'b1;
  endtask

  // Last stretch at full rate on both sides
  task automatic test_steady();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_frames(200);
  endtask

  // Main sequence
  initial begin
    error_count = 0;
    gaps_on     = 1'b0;
    stalls_on   = 1'b0;
    hold_req    = 1'b0;
    for (int i = 0; i < ORDER; i++) begin
      tap_wgt[i] = '0;
      past_x[i]  = '0;
    end
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= CMD_START;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random();
    test_backpressure();
    test_steady();

    // Drain outstanding results, then let the block settle
    s_axis_tvalid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tns_synthesis_fir test passed");
    end else begin
      $display("tns_synthesis_fir test failed");
    end
    $finish;
  end

endmodule
